>>> sv/lgsc_pkg.sv
`default_nettype none

package lgsc_pkg;

  localparam int LENGTH_FRAC_BITS = 16;
  localparam int GAIN_FRAC_BITS   = 16;
  localparam int COEF_FRAC_BITS   = 16;

  localparam int GAIN_COUNT = 12;
  localparam int TERM_COUNT = 4;
  localparam int LEG_W      = 16;
  localparam int GAIN_W     = 32;
  localparam int COEF_W     = 26;

  // growth of |acc| per Horner step when the leg length can exceed one unit
  localparam int LEN_GROW = (LENGTH_FRAC_BITS < LEG_W) ? (LEG_W - LENGTH_FRAC_BITS) : 0;
  localparam int ACC_W    = COEF_W + 3 * LEN_GROW + 3;
  localparam int PROD_W   = ACC_W + LEG_W + 1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef acc_t  [GAIN_COUNT-1:0]   acc_vec_t;
  typedef prod_t [GAIN_COUNT-1:0]   prod_vec_t;

  typedef struct packed {
    logic [LEG_W-1:0] leg_length;
    logic             airborne;
  } tag_t;

  // gains row 1 columns 0 and 1 survive while airborne
  localparam logic [GAIN_COUNT-1:0] AIR_KEEP = 12'b0000_1100_0000;

  // signed Q10.16 (26-bit) coefficients c0..c3 per gain, c0 on the cube
  localparam coef_t COEF_ROM [GAIN_COUNT][TERM_COUNT] = '{
    '{-26'sd6129404,  26'sd6916556,  -26'sd4479836, -26'sd31295},
    '{ 26'sd122573,  -26'sd182648,   -26'sd483788,   26'sd9664},
    '{-26'sd3458687,  26'sd3175474,  -26'sd1035643, -26'sd165178},
    '{-26'sd3152876,  26'sd2998967,  -26'sd1154262, -26'sd151620},
    '{-26'sd13373216, 26'sd13794554, -26'sd5480430,  26'sd1021018},
    '{-26'sd653705,   26'sd705123,   -26'sd301375,   26'sd65356},
    '{ 26'sd4095402, -26'sd3019518,   26'sd378656,   26'sd418910},
    '{ 26'sd847536,  -26'sd813960,    26'sd296446,   26'sd29137},
    '{-26'sd7880243,  26'sd8128519,  -26'sd3229374,  26'sd601640},
    '{-26'sd6752990,  26'sd7000927,  -26'sd2817503,  26'sd558276},
    '{ 26'sd24456611, -26'sd22453991, 26'sd7323099,  26'sd1167984},
    '{ 26'sd1503189, -26'sd1404185,   26'sd471015,   26'sd17849}
  };

endpackage

`default_nettype wire

>>> sv/lqr_gain_schedule_cubic_core.sv
`default_nettype none

// Leg-length scheduled 2x6 feedback gain matrix. Each transfer on the input
// stream carries an unsigned Q0.16 leg length and an airborne flag; each
// result transfer carries twelve signed Q16.16 gains, each a cubic in the leg
// length evaluated by Horner's rule against a fixed coefficient table and
// saturated to 32 bits. While airborne, row 0 and row 1 columns 2 to 5 read
// zero. The pipeline takes one item per cycle while the output is not stalled,
// with two register stages per Horner step (multiplier, then round and add)
// for three steps, plus the saturating output register. Backpressure on the
// output stalls the stages in place; nothing is dropped or repeated.

module lqr_gain_schedule_cubic_core
  import lgsc_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [15:0]                  in_tdata,   // [15:0] leg_length
  input  wire logic [0:0]                   in_tuser,   // [0] airborne
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [GAIN_COUNT*GAIN_W-1:0]      out_tdata   // gain_r0_c0 .. gain_r1_c5, 32 b each
);

  tag_t     in_tag;
  acc_vec_t c0_vec;

  logic     s_valid [TERM_COUNT];
  logic     s_ready [TERM_COUNT];
  tag_t     s_tag   [TERM_COUNT];
  acc_vec_t s_acc   [TERM_COUNT];

  assign in_tag.leg_length = in_tdata[LEG_W-1:0];
  assign in_tag.airborne   = in_tuser[0];

  always_comb begin
    for (int g = 0; g < GAIN_COUNT; g++) begin
      c0_vec[g] = ACC_W'(COEF_ROM[g][0]);
    end
  end

  assign s_valid[0] = in_tvalid;
  assign in_tready  = s_ready[0];
  assign s_tag[0]   = in_tag;
  assign s_acc[0]   = c0_vec;

  for (genvar k = 1; k < TERM_COUNT; k++) begin : g_step
    lgsc_horner_step #(
      .STEP(k)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (s_valid[k-1]),
      .up_ready (s_ready[k-1]),
      .up_tag   (s_tag[k-1]),
      .up_acc   (s_acc[k-1]),
      .dn_valid (s_valid[k]),
      .dn_ready (s_ready[k]),
      .dn_tag   (s_tag[k]),
      .dn_acc   (s_acc[k])
    );
  end

  lgsc_gain_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s_valid[TERM_COUNT-1]),
    .up_ready (s_ready[TERM_COUNT-1]),
    .up_tag   (s_tag[TERM_COUNT-1]),
    .up_acc   (s_acc[TERM_COUNT-1]),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (out_tdata)
  );

endmodule

`default_nettype wire

>>> sv/lgsc_horner_step.sv
`default_nettype none

module lgsc_horner_step
  import lgsc_pkg::*;
#(
  parameter int STEP = 1
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     up_valid,
  output logic          up_ready,
  input  wire tag_t     up_tag,
  input  wire acc_vec_t up_acc,
  output logic          dn_valid,
  input  wire logic     dn_ready,
  output tag_t          dn_tag,
  output acc_vec_t      dn_acc
);

  localparam prod_t RND_ONE = prod_t'(1) <<< (LENGTH_FRAC_BITS - 1);

  logic      mul_v_r;
  tag_t      mul_tag_r;
  prod_vec_t mul_prod_r;
  prod_vec_t mul_prod_nxt;
  logic      mul_ready;

  logic      add_v_r;
  tag_t      add_tag_r;
  acc_vec_t  add_acc_r;
  acc_vec_t  add_acc_nxt;
  logic      add_ready;

  prod_t     rnd_w [GAIN_COUNT];
  prod_t     sh_w  [GAIN_COUNT];

  assign add_ready = !add_v_r || dn_ready;
  assign mul_ready = !mul_v_r || add_ready;
  assign up_ready  = mul_ready;

  always_comb begin
    for (int g = 0; g < GAIN_COUNT; g++) begin
      mul_prod_nxt[g] = PROD_W'($signed(up_acc[g])) *
                        PROD_W'($signed({1'b0, up_tag.leg_length}));
    end
  end

  // round half up, drop the length fraction, add the next coefficient
  always_comb begin
    for (int g = 0; g < GAIN_COUNT; g++) begin
      rnd_w[g]       = $signed(mul_prod_r[g]) + RND_ONE;
      sh_w[g]        = rnd_w[g] >>> LENGTH_FRAC_BITS;
      add_acc_nxt[g] = sh_w[g][ACC_W-1:0] + ACC_W'(COEF_ROM[g][STEP]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      add_v_r <= 1'b0;
    end else begin
      if (mul_ready) mul_v_r <= up_valid;
      if (add_ready) add_v_r <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready) begin
      mul_tag_r  <= up_tag;
      mul_prod_r <= mul_prod_nxt;
    end
    if (add_ready) begin
      add_tag_r <= mul_tag_r;
      add_acc_r <= add_acc_nxt;
    end
  end

  assign dn_valid = add_v_r;
  assign dn_tag   = add_tag_r;
  assign dn_acc   = add_acc_r;

endmodule

`default_nettype wire

>>> sv/lgsc_gain_out.sv
`default_nettype none

module lgsc_gain_out
  import lgsc_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         up_valid,
  output logic                              up_ready,
  input  wire tag_t                         up_tag,
  input  wire acc_vec_t                     up_acc,
  output logic                              dn_valid,
  input  wire logic                         dn_ready,
  output logic [GAIN_COUNT*GAIN_W-1:0]      dn_data
);

  localparam int UP     = (GAIN_FRAC_BITS >= COEF_FRAC_BITS) ?
                          (GAIN_FRAC_BITS - COEF_FRAC_BITS) : 0;
  localparam int DOWN   = (GAIN_FRAC_BITS < COEF_FRAC_BITS) ?
                          (COEF_FRAC_BITS - GAIN_FRAC_BITS) : 0;
  localparam int CONV_W = (ACC_W + UP + 1 > GAIN_W + 1) ? (ACC_W + UP + 1) : (GAIN_W + 1);

  localparam logic signed [CONV_W-1:0] CONV_RND = (CONV_W'(1) << DOWN) >> 1;
  localparam logic signed [CONV_W-1:0] SAT_HI   = CONV_W'({1'b0, {(GAIN_W-1){1'b1}}});
  localparam logic signed [CONV_W-1:0] SAT_LO   = ~SAT_HI;

  logic signed [CONV_W-1:0] ext_w [GAIN_COUNT];
  logic signed [CONV_W-1:0] rnd_w [GAIN_COUNT];
  logic signed [CONV_W-1:0] cv_w  [GAIN_COUNT];
  logic [GAIN_W-1:0]        sat_w [GAIN_COUNT];

  logic                         data_v_r;
  logic [GAIN_COUNT*GAIN_W-1:0] data_r;
  logic [GAIN_COUNT*GAIN_W-1:0] data_nxt;

  assign up_ready = !data_v_r || dn_ready;

  always_comb begin
    for (int g = 0; g < GAIN_COUNT; g++) begin
      ext_w[g] = CONV_W'($signed(up_acc[g]));
      rnd_w[g] = ext_w[g] + CONV_RND;
      cv_w[g]  = (rnd_w[g] >>> DOWN) <<< UP;
      priority if (cv_w[g] > SAT_HI) begin
        sat_w[g] = SAT_HI[GAIN_W-1:0];
      end else if (cv_w[g] < SAT_LO) begin
        sat_w[g] = SAT_LO[GAIN_W-1:0];
      end else begin
        sat_w[g] = cv_w[g][GAIN_W-1:0];
      end
      if (up_tag.airborne && !AIR_KEEP[g]) begin
        data_nxt[g*GAIN_W +: GAIN_W] = '0;
      end else begin
        data_nxt[g*GAIN_W +: GAIN_W] = sat_w[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_v_r <= 1'b0;
    end else if (up_ready) begin
      data_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = data_v_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
module tb_top;
  import lgsc_pkg::*;

  localparam int PIPE_LATENCY = 7;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int R1C0_IDX     = 6;
  localparam int R1C1_IDX     = 7;
  localparam int VEC_W        = GAIN_COUNT * GAIN_W;

  // Q10.16 cubic coefficients per gain, cube term first
  localparam longint CUBIC_COEF [GAIN_COUNT][4] = '{
    '{ -6129404,   6916556,  -4479836,   -31295},
    '{   122573,   -182648,   -483788,     9664},
    '{ -3458687,   3175474,  -1035643,  -165178},
    '{ -3152876,   2998967,  -1154262,  -151620},
    '{-13373216,  13794554,  -5480430,  1021018},
    '{  -653705,    705123,   -301375,    65356},
    '{  4095402,  -3019518,    378656,   418910},
    '{   847536,   -813960,    296446,    29137},
    '{ -7880243,   8128519,  -3229374,   601640},
    '{ -6752990,   7000927,  -2817503,   558276},
    '{ 24456611, -22453991,   7323099,  1167984},
    '{  1503189,  -1404185,    471015,    17849}
  };

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [15:0]      in_tdata;   // [15:0] leg_length
  logic [0:0]       in_tuser;   // [0] airborne
  logic             out_tvalid;
  logic             out_tready;
  logic [VEC_W-1:0] out_tdata;  // gain_r0_c0 .. gain_r1_c5, 32 b each

  logic [VEC_W-1:0] gains_pending [$];
  int               mismatch_count;
  int               cycle_count;
  int               hold_left;
  int               stall_left;
  bit               no_idle;

  lqr_gain_schedule_cubic_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint rnd_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [VEC_W-1:0] predict_gains(logic [15:0] leg, logic air);
    logic [VEC_W-1:0] gains;
    longint           x;
    longint           acc;
    longint           v;
    x = longint'(leg);
    gains = '0;
    for (int g = 0; g < GAIN_COUNT; g++) begin
      acc = CUBIC_COEF[g][0];
      for (int k = 1; k < 4; k++) begin
        acc = rnd_shift(acc * x, LENGTH_FRAC_BITS) + CUBIC_COEF[g][k];
      end
      if (GAIN_FRAC_BITS >= COEF_FRAC_BITS) begin
        v = acc <<< (GAIN_FRAC_BITS - COEF_FRAC_BITS);
      end else begin
        v = rnd_shift(acc, COEF_FRAC_BITS - GAIN_FRAC_BITS);
      end
      if (v > longint'(32'sh7FFFFFFF)) v = longint'(32'sh7FFFFFFF);
      if (v < -longint'(64'h80000000)) v = -longint'(64'h80000000);
      if (air && g != R1C0_IDX && g != R1C1_IDX) v = 0;
      gains[g*GAIN_W +: GAIN_W] = v[GAIN_W-1:0];
    end
    return gains;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d, %s: got %h expected %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // check each result transfer against the oldest prediction
  always @(posedge clk) begin
    logic [VEC_W-1:0] want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (gains_pending.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata[31:0], 32'h0);
      end else begin
        want = gains_pending.pop_front();
        for (int g = 0; g < GAIN_COUNT; g++) begin
          if (out_tdata[g*GAIN_W +: GAIN_W] !== want[g*GAIN_W +: GAIN_W]) begin
            report_mismatch($sformatf("gain_r%0d_c%0d", g / 6, g % 6),
                            out_tdata[g*GAIN_W +: GAIN_W], want[g*GAIN_W +: GAIN_W]);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_tready = 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_tready = 1'b1;
    end
  end

  task automatic send_gains_item(logic [15:0] leg, logic air);
    in_tdata  = leg;
    in_tuser  = air;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gains_pending.push_back(predict_gains(leg, air));
    @(negedge clk);
  endtask

  task automatic idle_input(int n);
    in_tvalid = 1'b0;
    in_tdata  = 16'($urandom);
    in_tuser  = 1'($urandom);
    repeat (n) @(negedge clk);
  endtask

  task automatic maybe_idle_input();
    if (!no_idle && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 10));
  endtask

  task automatic wait_results_drained();
    in_tvalid = 1'b0;
    while (gains_pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_leg_length();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 3) return 16'($urandom_range(0, 255));
    if (sel < 6) return 16'($urandom_range(65280, 65535));
    return 16'($urandom);
  endfunction

  task automatic test_directed_lengths();
    logic [15:0] ground_lens [9];
    logic [15:0] air_lens [4];
    ground_lens = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
                    16'h5555, 16'hAAAA, 16'h4000, 16'hC000};
    air_lens    = '{16'h0000, 16'hFFFF, 16'h8000, 16'hAAAA};
    foreach (ground_lens[i]) send_gains_item(ground_lens[i], 1'b0);
    foreach (air_lens[i]) send_gains_item(air_lens[i], 1'b1);
    wait_results_drained();
  endtask

  task automatic test_random_stream(int count);
    repeat (count) begin
      maybe_idle_input();
      send_gains_item(pick_leg_length(), 1'($urandom));
    end
  endtask

  task automatic test_output_backpressure();
    hold_left = 200;
    repeat (40) send_gains_item(pick_leg_length(), 1'($urandom));
    wait_results_drained();
  endtask

  task automatic test_pause_until_drained();
    test_random_stream(10);
    wait_results_drained();
    test_random_stream(10);
    wait_results_drained();
  endtask

  task automatic test_full_rate();
    no_idle    = 1'b1;
    stall_left = 0;
    repeat (80) send_gains_item(16'($urandom), 1'($urandom));
    wait_results_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    hold_left      = 0;
    stall_left     = 0;
    no_idle        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_lengths();
    test_random_stream(300);
    test_output_backpressure();
    test_pause_until_drained();
    test_full_rate();

    wait_results_drained();
    repeat (2 * PIPE_LATENCY) @(negedge clk);
    if (mismatch_count == 0 && gains_pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lgsc_pkg.sv
sv/lgsc_horner_step.sv
sv/lgsc_gain_out.sv
sv/lqr_gain_schedule_cubic_core.sv
tb/sv/tb_top.sv
